// ----- sv/gbn_pkg.sv -----
// ----------------------------------------------------------------------------
// gbn_pkg: shared types, constants and microcode for the go-back-N sender
// Holds field widths, command and result codes, step addresses, the control
// word layout and the microcode table that drives the datapath.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int MAX_PACKETS_DEF = 64;

  localparam int CMD_W    = 2;
  localparam int CNT_IN_W = 7;
  localparam int WIN_W    = 4;
  localparam int ACK_W    = 8;
  localparam int SEQ_W    = 6;
  localparam int KIND_W   = 2;
  localparam int RETRY_W  = 3;
  localparam int UPC_W    = 4;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

  localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ABORT = 2'd3;

  localparam logic [RETRY_W-1:0] RETRY_RST = 3'd5;

  // Step addresses of the microprogram.
  localparam logic [UPC_W-1:0] S_IDLE   = 4'd0;
  localparam logic [UPC_W-1:0] S_DISP   = 4'd1;
  localparam logic [UPC_W-1:0] S_ERR    = 4'd2;
  localparam logic [UPC_W-1:0] S_START  = 4'd3;
  localparam logic [UPC_W-1:0] S_CHK    = 4'd4;
  localparam logic [UPC_W-1:0] S_GO     = 4'd5;
  localparam logic [UPC_W-1:0] S_DONE   = 4'd6;
  localparam logic [UPC_W-1:0] S_ACK    = 4'd7;
  localparam logic [UPC_W-1:0] S_ACHK   = 4'd8;
  localparam logic [UPC_W-1:0] S_ANEXT  = 4'd9;
  localparam logic [UPC_W-1:0] S_RESEND = 4'd10;
  localparam logic [UPC_W-1:0] S_TMO    = 4'd11;
  localparam logic [UPC_W-1:0] S_TCHK   = 4'd12;
  localparam logic [UPC_W-1:0] S_ABORT  = 4'd13;
  localparam logic [UPC_W-1:0] S_SEND   = 4'd14;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLR_ERR, OP_LOAD, OP_GO, OP_STOP,
    OP_ADV, OP_S_NEXT, OP_S_BASE, OP_INC_TO, OP_SEND
  } op_e;

  typedef enum logic [2:0] {
    C_ALWAYS, C_IN_ACC, C_DISPATCH, C_TOTAL_ZERO, C_BASE_END, C_TO_LIMIT, C_LAST_SEND
  } cond_e;

  typedef enum logic [2:0] {
    EM_NONE, EM_DATA, EM_ERROR, EM_DONE, EM_ABORT
  } emit_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    emit_e            emit;
    logic [UPC_W-1:0] tgt_t;
    logic [UPC_W-1:0] tgt_f;
  } uword_t;

  // Status from the datapath that the sequencer branches on.
  typedef struct packed {
    logic             total_zero;
    logic             base_end;
    logic             to_limit;
    logic             last_send;
    logic             s_lt_end;
    logic [UPC_W-1:0] disp;
  } flags_t;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic              last;
  } emit_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq;
    logic              last;
  } res_t;

  // Microcode ROM: one control word per step.
  function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
    uword_t w;
    unique case (addr)
      S_IDLE:   w = '{OP_NONE,    C_IN_ACC,     EM_NONE,  S_DISP,  S_IDLE};
      S_DISP:   w = '{OP_NONE,    C_DISPATCH,   EM_NONE,  S_IDLE,  S_IDLE};
      S_ERR:    w = '{OP_CLR_ERR, C_ALWAYS,     EM_ERROR, S_IDLE,  S_IDLE};
      S_START:  w = '{OP_LOAD,    C_ALWAYS,     EM_NONE,  S_CHK,   S_CHK};
      S_CHK:    w = '{OP_NONE,    C_TOTAL_ZERO, EM_NONE,  S_DONE,  S_GO};
      S_GO:     w = '{OP_GO,      C_ALWAYS,     EM_NONE,  S_SEND,  S_SEND};
      S_DONE:   w = '{OP_STOP,    C_ALWAYS,     EM_DONE,  S_IDLE,  S_IDLE};
      S_ACK:    w = '{OP_ADV,     C_ALWAYS,     EM_NONE,  S_ACHK,  S_ACHK};
      S_ACHK:   w = '{OP_NONE,    C_BASE_END,   EM_NONE,  S_DONE,  S_ANEXT};
      S_ANEXT:  w = '{OP_S_NEXT,  C_ALWAYS,     EM_NONE,  S_SEND,  S_SEND};
      S_RESEND: w = '{OP_S_BASE,  C_ALWAYS,     EM_NONE,  S_SEND,  S_SEND};
      S_TMO:    w = '{OP_INC_TO,  C_ALWAYS,     EM_NONE,  S_TCHK,  S_TCHK};
      S_TCHK:   w = '{OP_NONE,    C_TO_LIMIT,   EM_NONE,  S_ABORT, S_RESEND};
      S_ABORT:  w = '{OP_STOP,    C_ALWAYS,     EM_ABORT, S_IDLE,  S_IDLE};
      S_SEND:   w = '{OP_SEND,    C_LAST_SEND,  EM_DATA,  S_IDLE,  S_SEND};
      default:  w = '{OP_NONE,    C_ALWAYS,     EM_NONE,  S_IDLE,  S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- sv/gbn_datapath.sv -----
// ----------------------------------------------------------------------------
// gbn_datapath: transfer state registers of the go-back-N sender
// Holds the latched request, window bookkeeping and retry count, applies the
// operation of the current control word and reports branch flags.
// ----------------------------------------------------------------------------
module gbn_datapath
  import gbn_pkg::*;
#(
  parameter int MAX_PACKETS = MAX_PACKETS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_load_i,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [CNT_IN_W-1:0] packet_count_i,
  input  logic [WIN_W-1:0]    window_i,
  input  logic                file_found_i,
  input  logic [ACK_W-1:0]    ack_seq_i,
  input  logic                cfg_we_i,
  input  logic [RETRY_W-1:0]  cfg_data_i,
  input  op_e                 op_i,
  output flags_t              flags_o,
  output logic [SEQ_W-1:0]    seq_o
);

  localparam int CntW = $clog2(MAX_PACKETS + 1);
  localparam int SumW = ((CntW > WIN_W) ? CntW : WIN_W) + 1;
  localparam int CmpW = (CntW > CNT_IN_W) ? CntW : CNT_IN_W;

  logic [CMD_W-1:0]    cmd_q;
  logic [CNT_IN_W-1:0] cnt_q;
  logic [WIN_W-1:0]    win_in_q;
  logic                found_q;
  logic [ACK_W-1:0]    ack_q;

  logic                active_q, active_d;
  logic [CntW-1:0]     base_q, base_d;
  logic [CntW-1:0]     next_q, next_d;
  logic [CntW-1:0]     total_q, total_d;
  logic [WIN_W-1:0]    win_q, win_d;
  logic [RETRY_W-1:0]  to_q, to_d;
  logic [CntW-1:0]     s_q, s_d;
  logic [RETRY_W-1:0]  maxr_q;

  logic [SumW-1:0]       sum;
  logic [CntW-1:0]       end_v;
  logic [CntW-1:0]       total_ld;
  logic [CntW+ACK_W-1:0] base_x;
  logic                  match;

  always_ff @(posedge clk_i) begin
    if (in_load_i) begin
      cmd_q    <= command_i;
      cnt_q    <= packet_count_i;
      win_in_q <= window_i;
      found_q  <= file_found_i;
      ack_q    <= ack_seq_i;
    end
  end

  // Window end is the smaller of base plus window and the packet total.
  always_comb begin
    sum   = SumW'(base_q) + SumW'(win_q);
    end_v = (sum < SumW'(total_q)) ? CntW'(sum) : total_q;
    total_ld = (CmpW'(cnt_q) > CmpW'(MAX_PACKETS)) ? CntW'(MAX_PACKETS) : CntW'(cnt_q);
    base_x = (CntW + ACK_W)'(base_q);
    match  = (base_x[ACK_W-1:0] == ack_q);
  end

  always_comb begin
    flags_o.total_zero = (total_q == '0);
    flags_o.base_end   = (base_q >= total_q);
    flags_o.to_limit   = (to_q >= maxr_q);
    flags_o.s_lt_end   = (s_q < end_v);
    flags_o.last_send  = ((CntW + 1)'(s_q) + (CntW + 1)'(1)) >= (CntW + 1)'(end_v);
    unique case (cmd_q)
      CMD_START:   flags_o.disp = found_q ? S_START : S_ERR;
      CMD_ACK:     flags_o.disp = !active_q ? S_IDLE : (match ? S_ACK : S_RESEND);
      CMD_TIMEOUT: flags_o.disp = active_q ? S_TMO : S_IDLE;
      default:     flags_o.disp = S_IDLE;
    endcase
  end

  assign seq_o = SEQ_W'(s_q);

  always_comb begin
    active_d = active_q;
    base_d   = base_q;
    next_d   = next_q;
    total_d  = total_q;
    win_d    = win_q;
    to_d     = to_q;
    s_d      = s_q;
    unique case (op_i)
      OP_CLR_ERR: begin
        active_d = 1'b0;
        base_d   = '0;
        next_d   = '0;
        to_d     = '0;
        total_d  = '0;
        win_d    = WIN_W'(1);
      end
      OP_LOAD: begin
        base_d  = '0;
        next_d  = '0;
        to_d    = '0;
        total_d = total_ld;
        win_d   = (win_in_q == '0) ? WIN_W'(1) : win_in_q;
      end
      OP_GO: begin
        active_d = 1'b1;
        s_d      = '0;
      end
      OP_STOP:   active_d = 1'b0;
      OP_ADV: begin
        base_d = base_q + CntW'(1);
        to_d   = '0;
      end
      OP_S_NEXT: s_d = next_q;
      OP_S_BASE: s_d = base_q;
      OP_INC_TO: to_d = to_q + RETRY_W'(1);
      OP_SEND: begin
        if (s_q < end_v) begin
          s_d = s_q + CntW'(1);
        end
        if (end_v > next_q) begin
          next_d = end_v;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      base_q   <= '0;
      next_q   <= '0;
      total_q  <= '0;
      win_q    <= WIN_W'(1);
      to_q     <= '0;
      s_q      <= '0;
      maxr_q   <= RETRY_RST;
    end else begin
      active_q <= active_d;
      base_q   <= base_d;
      next_q   <= next_d;
      total_q  <= total_d;
      win_q    <= win_d;
      to_q     <= to_d;
      s_q      <= s_d;
      if (cfg_we_i) begin
        maxr_q <= cfg_data_i;
      end
    end
  end

`ifndef SYNTH
  a_win_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_q != '0) else $error("window size dropped to zero");
  a_next_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_q <= total_q) else $error("next unsent beyond packet total");
  a_base_le_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_q <= next_q) else $error("base passed the next unsent packet");
`endif

endmodule

// ----- sv/gbn_sequencer.sv -----
// ----------------------------------------------------------------------------
// gbn_sequencer: microprogram counter and branch logic
// Steps through the microcode table, selects the next address from the
// branch flags and holds the step while a result cannot be written out.
// ----------------------------------------------------------------------------
module gbn_sequencer
  import gbn_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_acc_i,
  input  flags_t flags_i,
  input  logic   out_free_i,
  output logic   in_ready_o,
  output op_e    op_o,
  output emit_t  emit_o
);

  logic [UPC_W-1:0] upc_q, upc_d;
  uword_t           word;
  logic             cond;
  logic             emit_req;
  logic             stall;
  logic [UPC_W-1:0] next_addr;

  always_comb begin
    word = ucode(upc_q);
    unique case (word.cond)
      C_ALWAYS:     cond = 1'b1;
      C_IN_ACC:     cond = in_acc_i;
      C_DISPATCH:   cond = 1'b1;
      C_TOTAL_ZERO: cond = flags_i.total_zero;
      C_BASE_END:   cond = flags_i.base_end;
      C_TO_LIMIT:   cond = flags_i.to_limit;
      C_LAST_SEND:  cond = flags_i.last_send;
      default:      cond = 1'b1;
    endcase
    // A data step emits only while the send pointer is inside the window.
    emit_req = (word.emit != EM_NONE) && !((word.emit == EM_DATA) && !flags_i.s_lt_end);
    stall    = emit_req && !out_free_i;
    if (!cond) begin
      next_addr = word.tgt_f;
    end else if (word.cond == C_DISPATCH) begin
      next_addr = flags_i.disp;
    end else begin
      next_addr = word.tgt_t;
    end
    upc_d = stall ? upc_q : next_addr;
    op_o  = stall ? OP_NONE : word.op;

    emit_o.valid = emit_req && out_free_i;
    emit_o.last  = (word.emit == EM_DATA) ? flags_i.last_send : 1'b1;
    unique case (word.emit)
      EM_ERROR: emit_o.kind = KIND_ERROR;
      EM_DONE:  emit_o.kind = KIND_DONE;
      EM_ABORT: emit_o.kind = KIND_ABORT;
      default:  emit_o.kind = KIND_DATA;
    endcase
  end

  assign in_ready_o = (upc_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

`ifndef SYNTH
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> $stable(upc_q)) else $error("step advanced while result was blocked");
`endif

endmodule

// ----- sv/gbn_out_reg.sv -----
// ----------------------------------------------------------------------------
// gbn_out_reg: result output register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module gbn_out_reg
  import gbn_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  input  logic ready_i,
  output logic free_o,
  output logic valid_o,
  output res_t res_o
);

  logic valid_q;
  res_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

`ifndef SYNTH
  a_seq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (res_q.kind != KIND_DATA)) |-> (res_q.seq == '0))
    else $error("non-data result carries a sequence number");
`endif

endmodule

// ----- sv/go_back_n_sender_top.sv -----
// ----------------------------------------------------------------------------
// go_back_n_sender_top: go-back-N ARQ sender control
// Turns start, ack and timeout requests into data sends, error, done and
// abort results under a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage: each request on the slave stream is a start, an ack, a receive
// timeout or an ignored packet (tuser). The master stream carries results:
// data sends with their sequence number, an error send, done or abort, with
// tlast set on the final result caused by one request. The config channel
// writes the retry limit and is always ready; write it only while idle.
// Throughput: a request is taken only when the sequencer sits in its idle
// step. After a request is accepted, the dispatch step and zero to three
// setup steps run before the first result; then one data send leaves per
// cycle from the send step while the output register is free, and the
// sequencer holds the send step while it is not.
// Reset: the retry limit returns to five, no transfer is active and the
// window is one. No clearing pass is needed.
// Stall: results go through a one-entry output register; when the receiver
// holds tready low the sequencer stays on its emitting step and no further
// requests are taken until the program returns to idle.
// ----------------------------------------------------------------------------
module go_back_n_sender_top
  import gbn_pkg::*;
#(
  parameter int MAX_PACKETS = MAX_PACKETS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // packet_count [6:0], window [10:7], file_found [11], ack_seq [19:12]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // command [1:0]
  input  logic [CMD_W-1:0]       s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // seq [5:0]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // kind [1:0]
  output logic [KIND_W-1:0]      m_axis_tuser,
  output logic                   m_axis_tlast,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [RETRY_W-1:0]     cfg_data_i
);

  logic             in_acc;
  flags_t           flags;
  op_e              op;
  emit_t            emit;
  logic             out_free;
  logic [SEQ_W-1:0] dp_seq;
  res_t             res_in;
  res_t             res_out;

  // The retry limit register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;
  assign in_acc      = s_axis_tvalid && s_axis_tready;

  gbn_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_acc_i   (in_acc),
    .flags_i    (flags),
    .out_free_i (out_free),
    .in_ready_o (s_axis_tready),
    .op_o       (op),
    .emit_o     (emit)
  );

  gbn_datapath #(
    .MAX_PACKETS (MAX_PACKETS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_load_i      (in_acc),
    .command_i      (s_axis_tuser),
    .packet_count_i (s_axis_tdata[6:0]),
    .window_i       (s_axis_tdata[10:7]),
    .file_found_i   (s_axis_tdata[11]),
    .ack_seq_i      (s_axis_tdata[19:12]),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .op_i           (op),
    .flags_o        (flags),
    .seq_o          (dp_seq)
  );

  // Only data sends carry a sequence number; all other results carry zero.
  always_comb begin
    res_in.kind = emit.kind;
    res_in.seq  = (emit.kind == KIND_DATA) ? dp_seq : '0;
    res_in.last = emit.last;
  end

  gbn_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (emit.valid),
    .res_i   (res_in),
    .ready_i (m_axis_tready),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .res_o   (res_out)
  );

  assign m_axis_tdata = OUT_TDATA_W'(res_out.seq);
  assign m_axis_tuser = res_out.kind;
  assign m_axis_tlast = res_out.last;

endmodule

// ----- test/go_back_n_sender_checker.sv -----
// ----------------------------------------------------------------------------
// go_back_n_sender_checker: result checker for the go-back-N sender
// Watches the request, result and retry-limit channels, predicts the sends,
// errors, done and abort results that each accepted request causes, and
// compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module go_back_n_sender_checker
  import gbn_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  input  logic                   req_ready_i,
  // packet_count [6:0], window [10:7], file_found [11], ack_seq [19:12]
  input  logic [IN_TDATA_W-1:0]  req_data_i,
  // command [1:0]
  input  logic [CMD_W-1:0]       req_user_i,
  input  logic                   res_valid_i,
  input  logic                   res_ready_i,
  // seq [5:0]
  input  logic [OUT_TDATA_W-1:0] res_data_i,
  // kind [1:0]
  input  logic [KIND_W-1:0]      res_user_i,
  input  logic                   res_last_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [RETRY_W-1:0]     cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PKT_LIMIT = MAX_PACKETS_DEF;

  logic [RETRY_W-1:0] retry_limit;
  logic               xfer_active;
  logic [6:0]         win_base;
  logic [6:0]         next_new;
  logic [6:0]         pkt_total;
  logic [WIN_W-1:0]   win_len;
  logic [RETRY_W-1:0] base_tmo;

  res_t planned_results[$];

  function automatic void plan_result(input logic [KIND_W-1:0] kind, input int seq);
    res_t r;
    r.kind = kind;
    r.seq  = seq[SEQ_W-1:0];
    r.last = 1'b0;
    planned_results.push_back(r);
  endfunction

  // Sends every sequence number from the given one up to the window end.
  function automatic void fill_window(input int from);
    int stop;
    int s;
    stop = int'(win_base) + int'(win_len);
    if (stop > int'(pkt_total)) stop = int'(pkt_total);
    for (s = from; s < stop; s++) plan_result(KIND_DATA, s);
    if (stop > int'(next_new)) next_new = stop[6:0];
  endfunction

  function automatic void plan_request(input logic [CMD_W-1:0] cmd,
                                       input logic [IN_TDATA_W-1:0] d);
    logic [6:0]       count;
    logic [WIN_W-1:0] win;
    logic             found;
    logic [ACK_W-1:0] ack;
    int               queued;
    res_t             tail;
    count  = d[6:0];
    win    = d[10:7];
    found  = d[11];
    ack    = d[19:12];
    queued = planned_results.size();
    if (cmd == CMD_START) begin
      win_base = '0;
      next_new = '0;
      base_tmo = '0;
      if (!found) begin
        xfer_active = 1'b0;
        pkt_total   = '0;
        win_len     = 4'd1;
        plan_result(KIND_ERROR, 0);
      end else begin
        pkt_total = (int'(count) > PKT_LIMIT) ? 7'(PKT_LIMIT) : count;
        win_len   = (win == '0) ? 4'd1 : win;
        if (pkt_total == '0) begin
          xfer_active = 1'b0;
          plan_result(KIND_DONE, 0);
        end else begin
          xfer_active = 1'b1;
          fill_window(0);
        end
      end
    end else if (cmd == CMD_ACK && xfer_active) begin
      if (ack == {1'b0, win_base}) begin
        win_base = win_base + 7'd1;
        base_tmo = '0;
        if (win_base >= pkt_total) begin
          xfer_active = 1'b0;
          plan_result(KIND_DONE, 0);
        end else begin
          fill_window(int'(next_new));
        end
      end else begin
        fill_window(int'(win_base));
      end
    end else if (cmd == CMD_TIMEOUT && xfer_active) begin
      base_tmo = base_tmo + 3'd1;
      if (base_tmo >= retry_limit) begin
        xfer_active = 1'b0;
        plan_result(KIND_ABORT, 0);
      end else begin
        fill_window(int'(win_base));
      end
    end
    if (planned_results.size() > queued) begin
      tail = planned_results.pop_back();
      tail.last = 1'b1;
      planned_results.push_back(tail);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    logic bad;
    if (!rst_ni) begin
      retry_limit = RETRY_RST;
      xfer_active = 1'b0;
      win_base    = '0;
      next_new    = '0;
      pkt_total   = '0;
      win_len     = 4'd1;
      base_tmo    = '0;
      planned_results.delete();
      pending_o <= 0;
    end else begin
      // Results are compared before the request of the same edge is planned.
      if (res_valid_i && res_ready_i) begin
        if (planned_results.size() == 0) begin
          $display("%0t: unexpected result, kind %0d tdata 0x%0h last %0b", $time,
                   res_user_i, res_data_i, res_last_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = planned_results.pop_front();
          bad  = 1'b0;
          if (res_user_i !== want.kind) begin
            $display("%0t: kind mismatch, expected %0d, actual %0d", $time,
                     want.kind, res_user_i);
            bad = 1'b1;
          end
          if (res_data_i !== OUT_TDATA_W'(want.seq)) begin
            $display("%0t: seq mismatch, expected 0x%0h, actual 0x%0h", $time,
                     OUT_TDATA_W'(want.seq), res_data_i);
            bad = 1'b1;
          end
          if (res_last_i !== want.last) begin
            $display("%0t: last mismatch, expected %0b, actual %0b", $time,
                     want.last, res_last_i);
            bad = 1'b1;
          end
          if (bad) fail_count_o <= fail_count_o + 1;
        end
      end
      if (req_valid_i && req_ready_i) plan_request(req_user_i, req_data_i);
      if (cfg_valid_i && cfg_ready_i) retry_limit = cfg_data_i;
      pending_o <= planned_results.size();
    end
  end

endmodule

// ----- test/go_back_n_sender_top_tb.sv -----
// ----------------------------------------------------------------------------
// go_back_n_sender_top_tb: stimulus and verdict for the go-back-N sender
// Drives directed and random transfers with random gaps on the request side
// and random stalls on the result side, rewrites the retry limit between
// phases, and leaves prediction and comparison to the checker beside the DUT.
// ----------------------------------------------------------------------------
module go_back_n_sender_top_tb;
  import gbn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // The package names start, ack and timeout; the fourth request kind is
  // any other packet, which the sender must ignore.
  localparam logic [CMD_W-1:0] CMD_OTHER = 2'd3;

  localparam int PHASE_QUOTA   = 30;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 1000000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0]       s_axis_tuser = CMD_OTHER;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]      m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [RETRY_W-1:0]     cfg_data_i = '0;

  int fail_count;
  int pending;
  int cycle_count = 0;

  // Idling switches, changed per phase so that some stretches run flat out.
  logic tx_idle_on = 1'b1;
  logic rx_idle_on = 1'b1;
  int   rx_hold = 0;

  // Retry limit last written, mirrored so that the random transfers know
  // when a run of timeouts has ended the transfer.
  logic [RETRY_W-1:0] retry_limit = RETRY_RST;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  go_back_n_sender_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  go_back_n_sender_checker watch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .req_user_i   (s_axis_tuser),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .res_user_i   (m_axis_tuser),
    .res_last_i   (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Mostly short gaps, now and then a long one that outlasts a full window.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 94) return $urandom_range(3, 7);
    return $urandom_range(12, 40);
  endfunction

  // Receiver: tready drops for a random stall, then comes back high. A
  // stall can start on any cycle, so it hits every step of the send loop.
  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
      rx_hold <= int'(gap_len()) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: the run cannot hang on a lost handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("go_back_n_sender_top test failed");
      $finish;
    end
  end

  // Presents one request and holds it until the sender takes it. When no
  // gap is drawn, tvalid simply stays high for the next request.
  task automatic issue_request(input logic [CMD_W-1:0] cmd, input logic [6:0] count,
                               input logic [WIN_W-1:0] win, input logic found,
                               input logic [ACK_W-1:0] ack);
    int unsigned gap;
    gap = (tx_idle_on && $urandom_range(0, 99) < 40) ? gap_len() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, ack, found, win, count};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drops tvalid, waits for every predicted result, then lets the sequencer
  // finish any request that produced nothing before the next step.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_retry_limit(input logic [RETRY_W-1:0] value);
    wait_for_drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    retry_limit = value;
  endtask

  // Random transfers: a start with random sizes followed mostly by in-order
  // acks, with wrong acks, timeouts and foreign packets mixed in. Only
  // requests that the sender acts on count toward the quota.
  task automatic run_transfers(input int quota);
    int               taken;
    int               events;
    int               r;
    int               base_pos;
    int               total;
    logic [6:0]       count;
    logic [WIN_W-1:0] win;
    logic             found;
    logic [ACK_W-1:0] ack;
    logic             live;
    logic [RETRY_W-1:0] tmo;
    taken = 0;
    while (taken < quota) begin
      found = ($urandom_range(0, 99) >= 4);
      r = $urandom_range(0, 99);
      if (r < 4) count = 7'd0;
      else if (r < 12) count = 7'($urandom_range(65, 127));
      else if (r < 22) count = 7'($urandom_range(13, 64));
      else count = 7'($urandom_range(1, 12));
      win = WIN_W'($urandom_range(0, 15));
      issue_request(CMD_START, count, win, found, ACK_W'($urandom_range(0, 255)));
      taken++;
      total    = (int'(count) > MAX_PACKETS_DEF) ? MAX_PACKETS_DEF : int'(count);
      live     = found && (total != 0);
      base_pos = 0;
      tmo      = '0;
      events   = 0;
      // A long transfer is cut short by the next start after forty events.
      while (live && events < 40 && taken < quota) begin
        r = $urandom_range(0, 99);
        if (r < 82) begin
          ack = (r < 72) ? ACK_W'(base_pos) : ACK_W'($urandom_range(0, 255));
          issue_request(CMD_ACK, 7'($urandom_range(0, 127)), WIN_W'($urandom_range(0, 15)),
                        1'($urandom_range(0, 1)), ack);
          if (ack == ACK_W'(base_pos)) begin
            base_pos++;
            tmo = '0;
            if (base_pos >= total) live = 1'b0;
          end
          taken++;
        end else if (r < 92) begin
          issue_request(CMD_TIMEOUT, 7'($urandom_range(0, 127)),
                        WIN_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                        ACK_W'($urandom_range(0, 255)));
          tmo = tmo + 3'd1;
          if (tmo >= retry_limit) live = 1'b0;
          taken++;
        end else begin
          issue_request(CMD_OTHER, 7'($urandom_range(0, 127)),
                        WIN_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                        ACK_W'($urandom_range(0, 255)));
        end
        events++;
      end
      // Now and then an ack or a timeout arrives with no transfer running.
      if (!live && $urandom_range(0, 9) == 0) begin
        issue_request($urandom_range(0, 1) ? CMD_ACK : CMD_TIMEOUT,
                      7'($urandom_range(0, 127)), WIN_W'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)), ACK_W'($urandom_range(0, 255)));
      end
    end
    // Close the phase with a missing-file start so no transfer stays open
    // across the register write.
    issue_request(CMD_START, 7'($urandom_range(0, 127)), WIN_W'($urandom_range(0, 15)),
                  1'b0, ACK_W'($urandom_range(0, 255)));
  endtask

  logic [RETRY_W-1:0] phase_limits [6] = '{3'd7, 3'd1, 3'd0, 3'd3, 3'd5, 3'd2};

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, run with the reset retry limit of five.
    // A missing file answers with one error send.
    issue_request(CMD_START, 7'd127, 4'd15, 1'b0, 8'hFF);
    // Ack, timeout and foreign packets with no transfer are all ignored.
    issue_request(CMD_ACK, 7'd0, 4'd0, 1'b1, 8'h00);
    issue_request(CMD_TIMEOUT, 7'd127, 4'd15, 1'b1, 8'hAA);
    issue_request(CMD_OTHER, 7'd64, 4'd8, 1'b0, 8'h55);
    // A zero packet count is done at once.
    issue_request(CMD_START, 7'd0, 4'd4, 1'b1, 8'h00);
    // A zero window behaves as a window of one.
    issue_request(CMD_START, 7'd3, 4'd0, 1'b1, 8'h00);
    issue_request(CMD_ACK, 7'd0, 4'd0, 1'b0, 8'd0);
    // A wrong ack and a timeout both resend the window.
    issue_request(CMD_ACK, 7'd0, 4'd0, 1'b0, 8'd7);
    issue_request(CMD_TIMEOUT, 7'd0, 4'd0, 1'b0, 8'd0);
    issue_request(CMD_OTHER, 7'd3, 4'd1, 1'b1, 8'd1);
    issue_request(CMD_ACK, 7'd0, 4'd0, 1'b0, 8'd1);
    issue_request(CMD_ACK, 7'd0, 4'd0, 1'b0, 8'd2);
    // A count above the packet limit saturates; the full window goes out.
    issue_request(CMD_START, 7'd127, 4'd15, 1'b1, 8'h80);
    // A start over a running transfer replaces it.
    issue_request(CMD_START, 7'd5, 4'd15, 1'b1, 8'h00);
    // The whole transfer is already out, so this ack opens no new slot.
    issue_request(CMD_ACK, 7'd0, 4'd0, 1'b0, 8'd0);
    issue_request(CMD_ACK, 7'd0, 4'd0, 1'b0, 8'hFF);
    // Four timeouts resend, the fifth reaches the limit and aborts.
    repeat (5) issue_request(CMD_TIMEOUT, 7'd0, 4'd0, 1'b0, 8'd0);

    // Random phases, each under its own retry limit. The first runs with
    // no idling at all, the second idles only on the request side.
    for (int p = 0; p < 6; p++) begin
      set_retry_limit(phase_limits[p]);
      tx_idle_on = (p != 0);
      rx_idle_on = (p > 1);
      run_transfers(PHASE_QUOTA);
    end

    wait_for_drain();
    if (pending != 0)
      $display("%0t: %0d expected results never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("go_back_n_sender_top test passed");
    end else begin
      $display("go_back_n_sender_top test failed");
    end
    $finish;
  end

endmodule
